// ===== sv/assert_macros.svh =====
// Assertion helper macros shared by the reuse time histogram RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RTHW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rthw check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define RTHW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rthw check failed");

`endif

// ===== sv/rthw_pkg.sv =====
// Shared types, constants and helpers for the reuse time histogram block.
// No dependencies; imported by every module of the block.
`default_nettype none

package rthw_pkg;

  localparam int REAL_BINS_DEF = 32;
  localparam int VIRT_BINS_DEF = 16;

  localparam int CNT_W   = 32;
  localparam int TIME_W  = 32;
  localparam int WEND_W  = 34;
  localparam int BIN_W   = 6;
  localparam int LV_W    = 5;
  localparam int SHIFT_W = 4;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;
  localparam int PADDR_W = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_GRAN      = 2'd0;
  localparam logic [1:0] REG_LOG_SHIFT = 2'd1;
  localparam logic [1:0] REG_WINDOW    = 2'd2;

  typedef enum logic [1:0] {
    KIND_WIN_REAL,
    KIND_WIN_VIRT,
    KIND_SKIP,
    KIND_READ
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_RD_GLOBAL,
    OP_EMIT_READ,
    OP_BIN_START,
    OP_LOOKUP,
    OP_UPDATE,
    OP_DUMP_REAL_RD,
    OP_EMIT_REAL,
    OP_DUMP_VIRT_RD,
    OP_EMIT_VIRT,
    OP_SKIP_START,
    OP_SKIP_DIV,
    OP_EMIT_SKIP
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic compulsory;
    logic div_busy;
    logic tw_zero;
    logic win_close;
    logic real_more;
    logic virt_more;
    logic skip_needed;
    logic out_free;
  } sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== sv/rthw_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rthw_pkg; shared by bin and skipped-window computations.
`default_nettype none
`include "assert_macros.svh"

module rthw_div (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       start,
  input  wire [rthw_pkg::TIME_W-1:0] dividend,
  input  wire [rthw_pkg::TIME_W-1:0] divisor,
  output logic                      busy,
  output logic [rthw_pkg::TIME_W-1:0] quot,
  output logic [rthw_pkg::TIME_W-1:0] rem
);
  import rthw_pkg::*;

  localparam int CNT_BITS = $clog2(TIME_W + 1);

  logic [CNT_BITS-1:0] cnt;
  logic [TIME_W-1:0]   dvs;
  logic [TIME_W:0]     trial;
  logic [TIME_W:0]     diff;

  assign trial = {rem, quot[TIME_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(TIME_W);
    end else if (busy) begin
      cnt <= cnt - CNT_BITS'(1);
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (!diff[TIME_W]) begin
        rem  <= diff[TIME_W-1:0];
        quot <= {quot[TIME_W-2:0], 1'b1};
      end else begin
        rem  <= trial[TIME_W-1:0];
        quot <= {quot[TIME_W-2:0], 1'b0};
      end
    end
  end

  `RTHW_ASSERT(a_no_restart, clk, rst, !(start && busy))
  `RTHW_ASSERT_NEXT(a_busy_after_start, clk, rst, start, busy)
  `RTHW_ASSERT(a_rem_below_divisor, clk, rst, busy ? (rem < dvs) : 1'b1)

endmodule

`default_nettype wire

// ===== sv/rthw_ctrl.sv =====
// Sequencer for the reuse time histogram: steps one word through capture,
// global read or binning, update, window dump and skip count. Depends on rthw_pkg.
`default_nettype none

module rthw_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            s_tvalid,
  output logic           s_tready,
  input  rthw_pkg::sts_t sts,
  output rthw_pkg::cmd_t cmd
);
  import rthw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_OUT,
    S_DIV,
    S_UPD,
    S_DR_CHK,
    S_DR_OUT,
    S_DV_CHK,
    S_DV_OUT,
    S_SK_START,
    S_SK_CHK,
    S_SK_DIV,
    S_SK_OUT
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_read) begin
          cmd.op     = OP_RD_GLOBAL;
          state_next = S_RD_OUT;
        end else if (sts.compulsory) begin
          cmd.op     = OP_LOOKUP;
          state_next = S_UPD;
        end else begin
          cmd.op     = OP_BIN_START;
          state_next = S_DIV;
        end
      end
      S_RD_OUT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_READ;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_LOOKUP;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.op = OP_UPDATE;
        if (sts.compulsory || sts.tw_zero || !sts.win_close) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_DR_CHK;
        end
      end
      S_DR_CHK: begin
        if (sts.real_more) begin
          cmd.op     = OP_DUMP_REAL_RD;
          state_next = S_DR_OUT;
        end else begin
          state_next = S_DV_CHK;
        end
      end
      S_DR_OUT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_REAL;
          state_next = S_DR_CHK;
        end
      end
      S_DV_CHK: begin
        if (sts.virt_more) begin
          cmd.op     = OP_DUMP_VIRT_RD;
          state_next = S_DV_OUT;
        end else begin
          state_next = S_SK_START;
        end
      end
      S_DV_OUT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_VIRT;
          state_next = S_DV_CHK;
        end
      end
      S_SK_START: begin
        cmd.op     = OP_SKIP_START;
        state_next = S_SK_CHK;
      end
      S_SK_CHK: begin
        if (sts.skip_needed) begin
          cmd.op     = OP_SKIP_DIV;
          state_next = S_SK_DIV;
        end else begin
          state_next = S_SK_OUT;
        end
      end
      S_SK_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_SK_OUT;
        end
      end
      S_SK_OUT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_SKIP;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rthw_dp.sv =====
// Datapath: captured word, histogram memories with valid bits, bin
// computation, window bookkeeping and output register. Uses rthw_pkg, rthw_div.
`default_nettype none
`include "assert_macros.svh"

module rthw_dp #(
  parameter int REAL_BINS = rthw_pkg::REAL_BINS_DEF,
  parameter int VIRT_BINS = rthw_pkg::VIRT_BINS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  rthw_pkg::cmd_t               cmd,
  output rthw_pkg::sts_t               sts,
  input  wire                          in_command,
  input  wire [rthw_pkg::TIME_W-1:0]   in_stamp,
  input  wire [rthw_pkg::TIME_W:0]     in_real_reuse_time,
  input  wire [rthw_pkg::TIME_W-1:0]   in_virtual_reuse_distance,
  input  wire                          in_read_kind,
  input  wire [rthw_pkg::BIN_W-1:0]    in_read_bin,
  input  wire [rthw_pkg::TIME_W-1:0]   rtime_granularity,
  input  wire [rthw_pkg::SHIFT_W-1:0]  log_base_shift,
  input  wire [rthw_pkg::TIME_W-1:0]   time_window,
  output logic                         out_valid,
  input  wire                          out_ready,
  output rthw_pkg::kind_t              out_kind,
  output logic [rthw_pkg::BIN_W-1:0]   out_bin,
  output logic [rthw_pkg::CNT_W-1:0]   out_count,
  output logic                         out_last
);
  import rthw_pkg::*;

  localparam int RA_W  = $clog2(REAL_BINS + 1);
  localparam int VA_W  = $clog2(VIRT_BINS + 1);
  localparam int WRA_W = $clog2(REAL_BINS);
  localparam int WVA_W = $clog2(VIRT_BINS);

  // captured word
  logic              c_read;
  logic              c_comp;
  logic [TIME_W-1:0] c_clock;
  logic [TIME_W-1:0] c_rt;
  logic [TIME_W-1:0] c_vd;
  logic              c_rkind;
  logic [BIN_W-1:0]  c_rbin;

  logic              started;
  logic [WEND_W-1:0] win_end;
  logic              skip_flag;

  logic [TIME_W-1:0]  gran_eff;
  logic [SHIFT_W-1:0] shift_eff;
  logic               tw_zero;
  logic [WEND_W-1:0]  clock_x;
  logic [WEND_W-1:0]  tw_x;

  assign gran_eff  = (rtime_granularity == '0) ? TIME_W'(1) : rtime_granularity;
  assign shift_eff = (log_base_shift == '0) ? SHIFT_W'(1) : log_base_shift;
  assign tw_zero   = (time_window == '0);
  assign clock_x   = WEND_W'(c_clock);
  assign tw_x      = WEND_W'(time_window);

  // shared divider
  logic              d_start, d_busy;
  logic [TIME_W-1:0] d_dividend, d_divisor, d_quot, d_rem;
  logic [WEND_W-1:0] skip_span;

  assign skip_span  = clock_x - win_end;
  assign d_start    = (cmd.op == OP_BIN_START) || (cmd.op == OP_SKIP_DIV);
  assign d_dividend = (cmd.op == OP_BIN_START) ? c_rt : skip_span[TIME_W-1:0];
  assign d_divisor  = (cmd.op == OP_BIN_START) ? gran_eff : time_window;

  rthw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (d_start),
    .dividend (d_dividend),
    .divisor  (d_divisor),
    .busy     (d_busy),
    .quot     (d_quot),
    .rem      (d_rem)
  );

  // floor(log2(vd) / shift), one halving per cycle alongside the divider
  logic [TIME_W-1:0]  lg_v;
  logic [SHIFT_W-1:0] lg_sub;
  logic [LV_W-1:0]    lv;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_BIN_START) begin
      lg_v   <= c_vd;
      lg_sub <= '0;
      lv     <= '0;
    end else if (lg_v > TIME_W'(1)) begin
      lg_v <= lg_v >> 1;
      if (lg_sub + SHIFT_W'(1) == shift_eff) begin
        lg_sub <= '0;
        lv     <= lv + LV_W'(1);
      end else begin
        lg_sub <= lg_sub + SHIFT_W'(1);
      end
    end
  end

  logic [WRA_W-1:0] rbin_c;
  logic [WVA_W-1:0] vbin_c;

  assign rbin_c = (d_quot > TIME_W'(REAL_BINS - 1)) ? WRA_W'(REAL_BINS - 1)
                                                     : d_quot[WRA_W-1:0];
  assign vbin_c = (TIME_W'(lv) > TIME_W'(VIRT_BINS - 1)) ? WVA_W'(VIRT_BINS - 1)
                                                          : WVA_W'(lv);

  // read command address and range check
  logic [8:0] rd9;
  logic       rd_oor;

  assign rd9    = {3'b000, c_rbin};
  assign rd_oor = c_rkind ? (32'(rd9) > 32'(VIRT_BINS)) : (32'(rd9) > 32'(REAL_BINS));

  // capture
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      c_read  <= in_command;
      c_comp  <= in_real_reuse_time[TIME_W];
      c_clock <= in_stamp;
      c_rt    <= in_real_reuse_time[TIME_W-1:0];
      c_vd    <= in_virtual_reuse_distance;
      c_rkind <= in_read_kind;
      c_rbin  <= in_read_bin;
    end
  end

  // global histograms
  logic [CNT_W-1:0] g_real [REAL_BINS+1];
  logic [CNT_W-1:0] g_virt [VIRT_BINS+1];
  logic [REAL_BINS:0] g_real_vld;
  logic [VIRT_BINS:0] g_virt_vld;
  logic [CNT_W-1:0] g_real_q, g_virt_q;
  logic [RA_W-1:0]  g_ra, lk_ra;
  logic [VA_W-1:0]  g_va, lk_va;

  always_comb begin
    if (cmd.op == OP_RD_GLOBAL) begin
      g_ra = rd9[RA_W-1:0];
      g_va = rd9[VA_W-1:0];
    end else if (c_comp) begin
      g_ra = RA_W'(REAL_BINS);
      g_va = VA_W'(VIRT_BINS);
    end else begin
      g_ra = RA_W'(rbin_c);
      g_va = VA_W'(vbin_c);
    end
  end

  // window histograms
  logic [CNT_W-1:0] w_real [REAL_BINS];
  logic [CNT_W-1:0] w_virt [VIRT_BINS];
  logic [REAL_BINS-1:0] w_real_vld;
  logic [VIRT_BINS-1:0] w_virt_vld;
  logic [CNT_W-1:0] w_real_q, w_virt_q;
  logic [WRA_W-1:0] w_ra, lk_wr;
  logic [WVA_W-1:0] w_va, lk_wv;
  logic [RA_W-1:0]  real_used, real_idx;
  logic [VA_W-1:0]  virt_used, virt_idx;
  logic             win_upd;

  assign w_ra    = (cmd.op == OP_DUMP_REAL_RD) ? real_idx[WRA_W-1:0] : rbin_c;
  assign w_va    = (cmd.op == OP_DUMP_VIRT_RD) ? virt_idx[WVA_W-1:0] : vbin_c;
  assign win_upd = (cmd.op == OP_UPDATE) && !c_comp && !tw_zero;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RD_GLOBAL || cmd.op == OP_LOOKUP) begin
      g_real_q <= g_real_vld[g_ra] ? g_real[g_ra] : '0;
      g_virt_q <= g_virt_vld[g_va] ? g_virt[g_va] : '0;
    end
    if (cmd.op == OP_LOOKUP) begin
      lk_ra <= g_ra;
      lk_va <= g_va;
      lk_wr <= rbin_c;
      lk_wv <= vbin_c;
    end
    if (cmd.op == OP_LOOKUP || cmd.op == OP_DUMP_REAL_RD) begin
      w_real_q <= w_real_vld[w_ra] ? w_real[w_ra] : '0;
    end
    if (cmd.op == OP_LOOKUP || cmd.op == OP_DUMP_VIRT_RD) begin
      w_virt_q <= w_virt_vld[w_va] ? w_virt[w_va] : '0;
    end
    if (cmd.op == OP_UPDATE) begin
      g_real[lk_ra] <= sat_inc(g_real_q);
      g_virt[lk_va] <= sat_inc(g_virt_q);
    end
    if (win_upd) begin
      w_real[lk_wr] <= sat_inc(w_real_q);
      w_virt[lk_wv] <= sat_inc(w_virt_q);
    end
  end

  // valid bits, window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      g_real_vld <= '0;
      g_virt_vld <= '0;
      w_real_vld <= '0;
      w_virt_vld <= '0;
      real_used  <= '0;
      virt_used  <= '0;
      real_idx   <= '0;
      virt_idx   <= '0;
      started    <= 1'b0;
      win_end    <= '0;
      skip_flag  <= 1'b0;
    end else begin
      if (cmd.op == OP_CAPTURE && !in_command && !started) begin
        win_end <= WEND_W'(in_stamp) + tw_x;
        started <= 1'b1;
      end
      if (cmd.op == OP_UPDATE) begin
        g_real_vld[lk_ra] <= 1'b1;
        g_virt_vld[lk_va] <= 1'b1;
        real_idx <= '0;
        virt_idx <= '0;
      end
      if (win_upd) begin
        w_real_vld[lk_wr] <= 1'b1;
        w_virt_vld[lk_wv] <= 1'b1;
        if (RA_W'(lk_wr) + RA_W'(1) > real_used) begin
          real_used <= RA_W'(lk_wr) + RA_W'(1);
        end
        if (VA_W'(lk_wv) + VA_W'(1) > virt_used) begin
          virt_used <= VA_W'(lk_wv) + VA_W'(1);
        end
      end
      if (cmd.op == OP_EMIT_REAL) begin
        real_idx <= real_idx + RA_W'(1);
      end
      if (cmd.op == OP_EMIT_VIRT) begin
        virt_idx <= virt_idx + VA_W'(1);
      end
      if (cmd.op == OP_SKIP_START) begin
        win_end   <= win_end + tw_x;
        skip_flag <= 1'b0;
      end
      if (cmd.op == OP_SKIP_DIV) begin
        skip_flag <= 1'b1;
      end
      if (cmd.op == OP_EMIT_SKIP) begin
        // end = clock - (clock - end) mod window + window
        if (skip_flag) begin
          win_end <= clock_x - WEND_W'(d_rem) + tw_x;
        end
        w_real_vld <= '0;
        w_virt_vld <= '0;
        real_used  <= '0;
        virt_used  <= '0;
      end
    end
  end

  // output register
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT_READ || cmd.op == OP_EMIT_REAL ||
          cmd.op == OP_EMIT_VIRT || cmd.op == OP_EMIT_SKIP) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_EMIT_READ: begin
        out_kind  <= KIND_READ;
        out_bin   <= c_rbin;
        out_count <= rd_oor ? '0 : (c_rkind ? g_virt_q : g_real_q);
        out_last  <= 1'b1;
      end
      OP_EMIT_REAL: begin
        out_kind  <= KIND_WIN_REAL;
        out_bin   <= BIN_W'(real_idx);
        out_count <= w_real_q;
        out_last  <= 1'b0;
      end
      OP_EMIT_VIRT: begin
        out_kind  <= KIND_WIN_VIRT;
        out_bin   <= BIN_W'(virt_idx);
        out_count <= w_virt_q;
        out_last  <= 1'b0;
      end
      OP_EMIT_SKIP: begin
        out_kind  <= KIND_SKIP;
        out_bin   <= '0;
        out_count <= !skip_flag ? '0 : ((d_quot == CNT_MAX) ? CNT_MAX
                                                            : d_quot + CNT_W'(1));
        out_last  <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.is_read     = c_read;
    sts.compulsory  = c_comp;
    sts.div_busy    = d_busy;
    sts.tw_zero     = tw_zero;
    sts.win_close   = (clock_x >= win_end);
    sts.real_more   = (real_idx < real_used);
    sts.virt_more   = (virt_idx < virt_used);
    sts.skip_needed = (clock_x >= win_end);
    sts.out_free    = out_free;
  end

  `RTHW_ASSERT(a_real_used_range, clk, rst, 32'(real_used) <= 32'(REAL_BINS))
  `RTHW_ASSERT(a_emit_needs_slot, clk, rst,
    !(cmd.op == OP_EMIT_READ || cmd.op == OP_EMIT_SKIP) || out_free)
  `RTHW_ASSERT_NEXT(a_skip_clears_used, clk, rst, cmd.op == OP_EMIT_SKIP,
    real_used == '0 && virt_used == '0)

endmodule

`default_nettype wire

// ===== sv/reuse_time_histogram_windowed_core.sv =====
// Reuse time histogram core: top level with stream ports and APB registers.
// Depends on rthw_pkg, rthw_ctrl, rthw_dp (and rthw_div below it).
//
// Slave stream: one word per request; tuser says record (0) or read (1).
// Master stream: result words; tlast marks the last result of a request.
// APB: rtime_granularity at 0x0, log_base_shift at 0x4, time_window at 0x8.
// One request is worked at a time; s_tready is high only while idle.
//  - read: one result.
//  - compulsory miss: no result.
//  - record: paced by the serial divider for
//    reuse_time / granularity (the log loop runs beside it).
//  - window close: plus one result per used window bin and the skip count,
//    which needs a division when whole windows were passed.
// A stalled m_tready holds the result register and pauses the sequencer
// before its next emit. Reset is synchronous; all histograms read zero after
// it through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module reuse_time_histogram_windowed_core #(
  parameter int REAL_BINS = rthw_pkg::REAL_BINS_DEF,
  parameter int VIRT_BINS = rthw_pkg::VIRT_BINS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // [31:0] timestamp, [64:32] real_reuse_time, [96:65] virtual_reuse_distance,
  // [102:97] read_bin, [103] zero
  input  wire [rthw_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [0] command, [1] read_kind
  input  wire [1:0]                          s_tuser,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // [5:0] bin_index, [37:6] count, [39:38] zero
  output logic [rthw_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // [1:0] result_kind
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [rthw_pkg::PADDR_W-1:0]        paddr,
  input  wire [31:0]                         pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import rthw_pkg::*;

  logic [TIME_W-1:0]  rtime_granularity;
  logic [SHIFT_W-1:0] log_base_shift;
  logic [TIME_W-1:0]  time_window;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rtime_granularity <= TIME_W'(1);
      log_base_shift    <= SHIFT_W'(1);
      time_window       <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_GRAN:      rtime_granularity <= pwdata;
        REG_LOG_SHIFT: log_base_shift    <= pwdata[SHIFT_W-1:0];
        REG_WINDOW:    time_window       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GRAN:      prdata = rtime_granularity;
      REG_LOG_SHIFT: prdata = 32'(log_base_shift);
      REG_WINDOW:    prdata = time_window;
      default:       prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;

  rthw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kind_t            out_kind;
  logic [BIN_W-1:0] out_bin;
  logic [CNT_W-1:0] out_count;

  rthw_dp #(
    .REAL_BINS (REAL_BINS),
    .VIRT_BINS (VIRT_BINS)
  ) u_dp (
    .clk                       (clk),
    .rst                       (rst),
    .cmd                       (cmd),
    .sts                       (sts),
    .in_command                (s_tuser[0]),
    .in_stamp                  (s_tdata[31:0]),
    .in_real_reuse_time        (s_tdata[64:32]),
    .in_virtual_reuse_distance (s_tdata[96:65]),
    .in_read_kind              (s_tuser[1]),
    .in_read_bin               (s_tdata[102:97]),
    .rtime_granularity         (rtime_granularity),
    .log_base_shift            (log_base_shift),
    .time_window               (time_window),
    .out_valid                 (m_tvalid),
    .out_ready                 (m_tready),
    .out_kind                  (out_kind),
    .out_bin                   (out_bin),
    .out_count                 (out_count),
    .out_last                  (m_tlast)
  );

  assign m_tdata = {2'b00, out_count, out_bin};
  assign m_tuser = out_kind;

endmodule

`default_nettype wire
